@@ src/fccm_pkg.sv @@
// fccm_pkg: shared types and constants of the cluster allocation table manager
// no dependencies, compiled first
package fccm_pkg;

	localparam int unsigned ENTRY_W = 28;
	localparam int unsigned COUNT_W = 12;
	localparam int unsigned OP_W    = 2;

	localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 28'h0FFFFFFF;
	localparam logic [ENTRY_W-1:0] BAD_LIMIT    = 28'h0FFFFFF8;
	localparam logic [ENTRY_W-1:0] FIRST_DATA   = 28'd2;
	localparam logic [COUNT_W-1:0] COUNT_RESET  = 12'd4094;

	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ALLOC = 2'd2,
		OP_FREE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_RANGE   = 2'd2,
		STAT_OVERRUN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_READ,
		RES_DONE,
		RES_RANGE,
		RES_ALLOC,
		RES_FULL,
		RES_OVERRUN
	} res_sel_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_READ_WAIT,
		S_SCAN,
		S_WALK_RD,
		S_WALK_WR,
		S_RESPOND
	} state_t;

	typedef struct packed {
		logic     clr_step;
		logic     load;
		logic     do_read;
		logic     do_write;
		logic     scan_step;
		logic     alloc_mark;
		logic     walk_read;
		logic     walk_zero;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_range;
		logic scan_hit;
		logic scan_end;
		logic walk_go;
		logic walk_valid;
	} sts_t;

endpackage

@@ src/fccm_if.sv @@
// fccm_if: valid/ready channel interfaces for request, response and configuration
// depends on fccm_pkg
interface fccm_req_if;
	logic                             valid;
	logic                             ready;
	logic [fccm_pkg::OP_W-1:0]        opcode;
	fccm_pkg::entry_t                 cluster;
	fccm_pkg::entry_t                 value;

	modport source (output valid, output opcode, output cluster, output value, input ready);
	modport sink   (input valid, input opcode, input cluster, input value, output ready);
endinterface

interface fccm_rsp_if;
	logic              valid;
	logic              ready;
	fccm_pkg::entry_t  result_value;
	fccm_pkg::status_t status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink   (input valid, input result_value, input status, output ready);
endinterface

interface fccm_cfg_if;
	logic             valid;
	logic             ready;
	fccm_pkg::count_t cluster_count;

	modport source (output valid, output cluster_count, input ready);
	modport sink   (input valid, input cluster_count, output ready);
endinterface

@@ src/fccm_datapath.sv @@
// fccm_datapath: allocation table memory, scan and chain walk pointers, result register
// depends on fccm_pkg; driven by fccm_ctrl through cmd_t, reports through sts_t
module fccm_datapath #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fccm_pkg::cmd_t             cmd,
	output fccm_pkg::sts_t             sts,
	input  fccm_pkg::entry_t           req_cluster,
	input  fccm_pkg::entry_t           req_value,
	input  logic                       cfg_we,
	input  fccm_pkg::count_t           cfg_count,
	output fccm_pkg::entry_t           result_value,
	output fccm_pkg::status_t          status
);
	import fccm_pkg::*;

	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned LIM_W  = ADDR_W + 1;
	localparam int unsigned CP_W   = COUNT_W + 1;

	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_data_q;
	count_t            count_q;
	entry_t            cl_q;
	entry_t            val_q;
	entry_t            cur_q;
	logic [LIM_W-1:0]  steps_q;
	logic [LIM_W-1:0]  ptr_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	entry_t            result_q;
	status_t           status_q;

	logic [CP_W-1:0]   cnt_plus2;
	logic [LIM_W-1:0]  limit;
	logic [LIM_W-1:0]  bound;
	logic              ptr_below;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;

	// table limit and walk bound
	assign cnt_plus2 = CP_W'(count_q) + CP_W'(2);
	assign limit     = (32'(cnt_plus2) >= 32'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
	                                                         : LIM_W'(cnt_plus2);
	assign bound     = (limit > LIM_W'(2)) ? limit - LIM_W'(2) : '0;
	assign ptr_below = ptr_q < limit;

	assign sts.clr_last   = ptr_q == LIM_W'(TABLE_DEPTH - 1);
	assign sts.in_range   = cl_q < ENTRY_W'(limit);
	assign sts.scan_hit   = rd_vld_s1 && (rd_data_q == '0);
	assign sts.scan_end   = !rd_vld_s1 && !ptr_below;
	assign sts.walk_valid = (cur_q >= FIRST_DATA) && (cur_q < ENTRY_W'(limit))
	                        && (cur_q < BAD_LIMIT);
	assign sts.walk_go    = sts.walk_valid && (steps_q < bound);

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cl_q[ADDR_W-1:0];
		if (cmd.do_read) begin
			rd_en = 1'b1;
		end else if (cmd.scan_step) begin
			rd_en   = ptr_below;
			rd_addr = ptr_q[ADDR_W-1:0];
		end else if (cmd.walk_read) begin
			rd_en   = 1'b1;
			rd_addr = cur_q[ADDR_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[ADDR_W-1:0];
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.do_write) begin
			wr_en   = 1'b1;
			wr_addr = cl_q[ADDR_W-1:0];
			wr_data = val_q;
		end else if (cmd.alloc_mark) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
			wr_data = END_OF_CHAIN;
		end else if (cmd.walk_zero) begin
			wr_en   = 1'b1;
			wr_addr = cur_q[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_count;
		end
	end

	// pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			steps_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				ptr_q <= ptr_q + LIM_W'(1);
			end else if (cmd.load) begin
				ptr_q     <= LIM_W'(2);
				steps_q   <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_vld_s1 <= ptr_below;
				if (ptr_below) begin
					ptr_q <= ptr_q + LIM_W'(1);
				end
			end else if (cmd.walk_zero) begin
				steps_q <= steps_q + LIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cl_q  <= req_cluster;
			val_q <= req_value;
			cur_q <= req_cluster;
		end else if (cmd.walk_zero) begin
			cur_q <= rd_data_q;
		end
		if (cmd.scan_step) begin
			rd_addr_s1 <= ptr_q[ADDR_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_sel)
				RES_READ: begin
					result_q <= rd_data_q;
					status_q <= STAT_OK;
				end
				RES_ALLOC: begin
					result_q <= ENTRY_W'(rd_addr_s1);
					status_q <= STAT_OK;
				end
				RES_RANGE: begin
					result_q <= '0;
					status_q <= STAT_RANGE;
				end
				RES_FULL: begin
					result_q <= '0;
					status_q <= STAT_FULL;
				end
				RES_OVERRUN: begin
					result_q <= '0;
					status_q <= STAT_OVERRUN;
				end
				default: begin
					result_q <= '0;
					status_q <= STAT_OK;
				end
			endcase
		end
	end

	assign result_value = result_q;
	assign status       = status_q;

endmodule

@@ src/fccm_ctrl.sv @@
// fccm_ctrl: controller state machine sequencing clear, read, write, allocate and free
// depends on fccm_pkg; drives fccm_datapath through cmd_t
module fccm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [fccm_pkg::OP_W-1:0] req_opcode,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  fccm_pkg::sts_t            sts,
	output fccm_pkg::cmd_t            cmd
);
	import fccm_pkg::*;

	state_t   state_q;
	state_t   state_d;
	opcode_t  op_q;
	res_sel_t res_sel_q;
	res_sel_t res_d;
	logic     res_set;
	logic     out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (op_q)
					OP_READ:  state_d = sts.in_range ? S_READ_WAIT : S_RESPOND;
					OP_WRITE: state_d = S_RESPOND;
					OP_ALLOC: state_d = S_SCAN;
					OP_FREE:  state_d = S_WALK_RD;
					default:  state_d = S_RESPOND;
				endcase
			end
			S_READ_WAIT: state_d = S_RESPOND;
			S_SCAN: begin
				if (sts.scan_hit || sts.scan_end) state_d = S_RESPOND;
			end
			S_WALK_RD: state_d = sts.walk_go ? S_WALK_WR : S_RESPOND;
			S_WALK_WR: state_d = S_WALK_RD;
			S_RESPOND: begin
				if (!out_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.res_sel = res_sel_q;
		req_ready   = 1'b0;
		res_set     = 1'b0;
		res_d       = RES_DONE;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_DISPATCH: begin
				unique case (op_q)
					OP_READ: begin
						if (sts.in_range) begin
							cmd.do_read = 1'b1;
						end else begin
							res_set = 1'b1;
							res_d   = RES_RANGE;
						end
					end
					OP_WRITE: begin
						res_set = 1'b1;
						if (sts.in_range) begin
							cmd.do_write = 1'b1;
							res_d        = RES_DONE;
						end else begin
							res_d = RES_RANGE;
						end
					end
					default: ;
				endcase
			end
			S_READ_WAIT: begin
				res_set = 1'b1;
				res_d   = RES_READ;
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					cmd.alloc_mark = 1'b1;
					res_set        = 1'b1;
					res_d          = RES_ALLOC;
				end else if (sts.scan_end) begin
					res_set = 1'b1;
					res_d   = RES_FULL;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_WALK_RD: begin
				if (sts.walk_go) begin
					cmd.walk_read = 1'b1;
				end else begin
					res_set = 1'b1;
					res_d   = sts.walk_valid ? RES_OVERRUN : RES_DONE;
				end
			end
			S_WALK_WR: cmd.walk_zero = 1'b1;
			S_RESPOND: cmd.out_load = !out_valid_q || rsp_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_sel_q   <= RES_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_set) begin
				res_sel_q <= res_d;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode_t'(req_opcode);
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

@@ src/fat_cluster_chain_manager_core.sv @@
// after acceptance: read goes dispatch, table read, respond (no read out of range); write
// goes dispatch, respond; allocate scans entries; free reads and clears each link visited
// one item in flight; the next is taken the cycle after its result is registered
// the single-port table read, one entry a cycle, sets the allocate rate (up to TABLE_DEPTH - 2)
// reset clears every table entry in a clearing pass, no item taken meanwhile
// depends on fccm_pkg, fccm_if, fccm_ctrl and fccm_datapath
module fat_cluster_chain_manager_core #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	fccm_req_if.sink   req,
	fccm_rsp_if.source rsp,
	fccm_cfg_if.sink   cfg
);
	import fccm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	fccm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	fccm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_cluster  (req.cluster),
		.req_value    (req.value),
		.cfg_we       (cfg.valid),
		.cfg_count    (cfg.cluster_count),
		.result_value (rsp.result_value),
		.status       (rsp.status)
	);

	// one item at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while another is in progress");

	// no item taken during the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !req.ready)
		else $error("item accepted during table clear");

	// any error status carries a zero result
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_OK) |-> (rsp.result_value == '0))
		else $error("error result with non-zero value");

	// a found free entry always leads to a response
	a_alloc_respond: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_mark |=> (cmd.res_sel == RES_ALLOC))
		else $error("allocation not reported");

endmodule

@@ dv/fat_cluster_chain_manager_core_tb.sv @@
// fat_cluster_chain_manager_core_tb: self-checking bench for the cluster allocation table manager
// drives read, write, allocate and free requests, predicts every result item and compares it
// depends on fccm_pkg, fccm_if and fat_cluster_chain_manager_core
module fat_cluster_chain_manager_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fccm_pkg::*;

	localparam int unsigned FAT_DEPTH   = 4096;
	localparam int unsigned STUCK_LIMIT = 60000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned END_CYCLES  = 20;

	typedef struct {
		bit      is_cfg;
		count_t  count;
		opcode_t op;
		entry_t  cl;
		entry_t  val;
		bit      typed;
		entry_t  exp_val;
		status_t exp_st;
	} stim_t;

	typedef struct {
		entry_t  val;
		status_t st;
	} answer_t;

	logic clk;
	logic arst_n;

	fccm_req_if req ();
	fccm_rsp_if rsp ();
	fccm_cfg_if cfg ();

	fat_cluster_chain_manager_core #(
		.TABLE_DEPTH(FAT_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	entry_t      fat_model [FAT_DEPTH];
	count_t      count_model;
	count_t      cfg_now;
	answer_t     pending_answers[$];
	stim_t       req_meta;
	stim_t       directed_rows[$];
	int unsigned burst_left;
	bit          sender_steady;
	bit          hold_off;
	int unsigned stuck_cycles;
	int unsigned errors;
	int unsigned n_items;
	int unsigned n_results;
	int unsigned n_settings;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic bit is_data_cluster(entry_t c, int unsigned lim);
		return c >= FIRST_DATA && c < lim && c < BAD_LIMIT;
	endfunction

	function automatic void apply_fat_op(input opcode_t op, input entry_t cl, input entry_t val,
			output entry_t res, output status_t st);
		int unsigned lim;
		int unsigned bound;
		int unsigned steps;
		int unsigned c;
		entry_t      cur;
		entry_t      nxt;
		lim = int'(count_model) + 2;
		if (lim > FAT_DEPTH) begin
			lim = FAT_DEPTH;
		end
		res = '0;
		st  = STAT_OK;
		case (op)
			OP_READ: begin
				if (cl < lim) begin
					res = fat_model[cl];
				end else begin
					st = STAT_RANGE;
				end
			end
			OP_WRITE: begin
				if (cl < lim) begin
					fat_model[cl] = val;
				end else begin
					st = STAT_RANGE;
				end
			end
			OP_ALLOC: begin
				st = STAT_FULL;
				for (c = 2; c < lim && st == STAT_FULL; c++) begin
					if (fat_model[c] == '0) begin
						fat_model[c] = END_OF_CHAIN;
						res = entry_t'(c);
						st = STAT_OK;
					end
				end
			end
			default: begin
				bound = (lim > 2) ? lim - 2 : 0;
				steps = 0;
				cur = cl;
				while (is_data_cluster(cur, lim) && steps < bound) begin
					nxt = fat_model[cur];
					fat_model[cur] = '0;
					cur = nxt;
					steps++;
				end
				if (is_data_cluster(cur, lim)) begin
					st = STAT_OVERRUN;
				end
			end
		endcase
	endfunction

	function automatic stim_t op_row(opcode_t op, entry_t cl, entry_t val);
		stim_t s;
		s = '{is_cfg: 1'b0, count: '0, op: op, cl: cl, val: val, typed: 1'b0,
			exp_val: '0, exp_st: STAT_OK};
		return s;
	endfunction

	function automatic stim_t chk_row(opcode_t op, entry_t cl, entry_t val, entry_t ev,
			status_t es);
		stim_t s;
		s = op_row(op, cl, val);
		s.typed = 1'b1;
		s.exp_val = ev;
		s.exp_st = es;
		return s;
	endfunction

	function automatic stim_t cfg_row(count_t c);
		stim_t s;
		s = op_row(OP_READ, '0, '0);
		s.is_cfg = 1'b1;
		s.count = c;
		return s;
	endfunction

	task automatic offer_request(input stim_t s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (!sender_steady && $urandom_range(0, 3) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.opcode <= s.op;
		req.cluster <= s.cl;
		req.value <= s.val;
		req_meta <= s;
		do @(posedge clk); while (req.ready !== 1'b1);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	task automatic set_cluster_count(input count_t c);
		drain();
		cfg.valid <= 1'b1;
		cfg.cluster_count <= c;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		cfg_now = c;
		n_settings++;
	endtask

	task automatic run_phase(input int unsigned n_req);
		int unsigned lim;
		int unsigned done;
		int unsigned r;
		int unsigned len;
		int unsigned tail;
		int unsigned k;
		entry_t      links[4];
		entry_t      nxt;
		lim = int'(cfg_now) + 2;
		if (lim > FAT_DEPTH) begin
			lim = FAT_DEPTH;
		end
		done = 0;
		while (done < n_req) begin
			r = $urandom_range(0, 99);
			if (r < 35 && lim > 2) begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++) begin
					links[k] = entry_t'($urandom_range(2, lim - 1));
				end
				tail = $urandom_range(0, 9);
				for (k = 0; k < len; k++) begin
					if (k < len - 1) begin
						nxt = links[k + 1];
					end else if (tail == 0) begin
						nxt = links[0];
					end else if (tail == 1) begin
						nxt = entry_t'($urandom());
					end else begin
						nxt = END_OF_CHAIN;
					end
					offer_request(op_row(OP_WRITE, links[k], nxt));
					done++;
				end
				if ($urandom_range(0, 4) != 0) begin
					offer_request(op_row(OP_FREE, links[0], entry_t'($urandom())));
					done++;
				end
			end else if (r < 55) begin
				repeat ($urandom_range(1, 3)) begin
					offer_request(op_row(OP_ALLOC, entry_t'($urandom()), entry_t'($urandom())));
					done++;
				end
			end else if (r < 75) begin
				offer_request(op_row(OP_READ, entry_t'($urandom_range(0, lim - 1)),
					entry_t'($urandom())));
				done++;
			end else if (r < 85) begin
				if ($urandom_range(0, 1) == 0) begin
					nxt = entry_t'($urandom());
				end else begin
					nxt = entry_t'($urandom_range(2, lim + 1));
				end
				offer_request(op_row(OP_WRITE, entry_t'($urandom_range(0, lim - 1)), nxt));
				done++;
			end else if (r < 95) begin
				offer_request(op_row(OP_FREE, entry_t'($urandom_range(0, lim - 1)),
					entry_t'($urandom())));
				done++;
			end else begin
				offer_request(op_row(opcode_t'($urandom_range(0, 3)), entry_t'($urandom()),
					entry_t'($urandom())));
				done++;
			end
		end
	endtask

	always @(posedge clk) begin
		entry_t  pv;
		status_t ps;
		answer_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				count_model = cfg.cluster_count;
			end
			if (req.valid && req.ready) begin
				apply_fat_op(opcode_t'(req.opcode), req.cluster, req.value, pv, ps);
				if (req_meta.typed) begin
					pv = req_meta.exp_val;
					ps = req_meta.exp_st;
				end
				pending_answers.push_back('{val: pv, st: ps});
				n_items++;
			end
			if (rsp.valid && rsp.ready) begin
				n_results++;
				if (pending_answers.size() == 0) begin
					$error("result item with nothing pending: result_value %0h status %0d",
						rsp.result_value, rsp.status);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp.result_value !== want.val) begin
						$error("result_value: expected %0h, got %0h", want.val, rsp.result_value);
						errors++;
					end
					if (rsp.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, rsp.status);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
					|| (cfg.valid && cfg.ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned stall;
		int unsigned mode_left;
		bit          smooth;
		rsp.ready = 1'b0;
		stall = 0;
		mode_left = 0;
		smooth = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			if (mode_left == 0) begin
				smooth = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (smooth) begin
				rsp.ready <= 1'b1;
			end else if (stall > 0) begin
				rsp.ready <= 1'b0;
				stall--;
			end else if ($urandom_range(0, 3) == 0) begin
				stall = $urandom_range(0, 6);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned phase_counts[8];
		for (int i = 0; i < FAT_DEPTH; i++) begin
			fat_model[i] = '0;
		end
		count_model = COUNT_RESET;
		cfg_now = COUNT_RESET;
		burst_left = 0;
		sender_steady = 1'b0;
		hold_off = 1'b0;
		stuck_cycles = 0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_settings = 0;
		req.valid = 1'b0;
		req.opcode = OP_READ;
		req.cluster = '0;
		req.value = '0;
		req_meta = op_row(OP_READ, '0, '0);
		cfg.valid = 1'b0;
		cfg.cluster_count = '0;
		phase_counts = '{6, 1, 24, 4094, 3, 64, 4095, 12};

		directed_rows.push_back(chk_row(OP_READ, 28'd2, '0, '0, STAT_OK));
		directed_rows.push_back(chk_row(OP_READ, 28'd0, '0, '0, STAT_OK));
		directed_rows.push_back(chk_row(OP_READ, 28'h0FFFFFFF, '0, '0, STAT_RANGE));
		directed_rows.push_back(chk_row(OP_WRITE, 28'h0FFFFFFF, 28'h0FFFFFFF, '0, STAT_RANGE));
		directed_rows.push_back(chk_row(OP_WRITE, 28'd1, 28'h0FFFFFFF, '0, STAT_OK));
		directed_rows.push_back(chk_row(OP_READ, 28'd1, '0, 28'h0FFFFFFF, STAT_OK));
		directed_rows.push_back(chk_row(OP_ALLOC, '0, '0, 28'd2, STAT_OK));
		directed_rows.push_back(chk_row(OP_ALLOC, '0, '0, 28'd3, STAT_OK));
		directed_rows.push_back(op_row(OP_WRITE, 28'd4095, 28'h5555555));
		directed_rows.push_back(op_row(OP_WRITE, 28'd0, 28'hAAAAAAA));
		directed_rows.push_back(op_row(OP_WRITE, 28'd2, 28'd3));
		directed_rows.push_back(op_row(OP_WRITE, 28'd3, 28'd4));
		directed_rows.push_back(op_row(OP_WRITE, 28'd4, 28'hAAAAAAA));
		directed_rows.push_back(op_row(OP_FREE, 28'd2, '0));
		directed_rows.push_back(op_row(OP_READ, 28'd4, '0));
		directed_rows.push_back(chk_row(OP_FREE, 28'd0, '0, '0, STAT_OK));
		directed_rows.push_back(cfg_row(12'd2));
		directed_rows.push_back(op_row(OP_WRITE, 28'd2, 28'd3));
		directed_rows.push_back(op_row(OP_WRITE, 28'd3, 28'd2));
		directed_rows.push_back(chk_row(OP_FREE, 28'd2, '0, '0, STAT_OVERRUN));
		directed_rows.push_back(chk_row(OP_ALLOC, '0, '0, 28'd2, STAT_OK));
		directed_rows.push_back(chk_row(OP_ALLOC, '0, '0, 28'd3, STAT_OK));
		directed_rows.push_back(chk_row(OP_ALLOC, '0, '0, '0, STAT_FULL));
		directed_rows.push_back(cfg_row(12'd0));
		directed_rows.push_back(chk_row(OP_ALLOC, '0, '0, '0, STAT_FULL));
		directed_rows.push_back(chk_row(OP_FREE, 28'd2, '0, '0, STAT_OK));
		directed_rows.push_back(chk_row(OP_READ, 28'd2, '0, '0, STAT_RANGE));
		directed_rows.push_back(cfg_row(12'd4095));
		directed_rows.push_back(chk_row(OP_READ, 28'd4095, '0, 28'h5555555, STAT_OK));

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				set_cluster_count(directed_rows[i].count);
			end else begin
				offer_request(directed_rows[i]);
			end
		end

		foreach (phase_counts[p]) begin
			set_cluster_count(count_t'(phase_counts[p]));
			sender_steady = (p == 5);
			if (p == 2) begin
				hold_off = 1'b1;
			end
			run_phase(14);
		end

		drain();
		repeat (END_CYCLES) @(posedge clk);
		$display("ran %0d requests through %0d cluster_count settings, %0d results checked",
			n_items, n_settings, n_results);
		$display("read, write, allocate to full, chain free with overrun, out-of-range access");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
